>>> sv/trmx_pkg.sv
// Shared types, codes and sizes for the register machine execute stage.
`default_nettype none

package trmx_pkg;

    // Sizes
    localparam int unsigned NUM_REGS   = 32;
    localparam int unsigned REG_IDX_W  = $clog2(NUM_REGS);
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned MEM_WORDS  = 256;
    localparam int unsigned MEM_ADDR_W = 8;
    localparam int unsigned IMM_W      = 16;
    localparam int unsigned OP_W       = 4;
    localparam int unsigned STATUS_W   = 3;

    // Operation codes; codes above OP_NOP are invalid
    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_ADDI = 4'd1,
        OP_SUB  = 4'd2,
        OP_MULT = 4'd3,
        OP_LES  = 4'd4,
        OP_EQL  = 4'd5,
        OP_LW   = 4'd6,
        OP_SW   = 4'd7,
        OP_HALT = 4'd8,
        OP_NOP  = 4'd9
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_BOUNDS  = 3'd1,
        ST_HALTED  = 3'd2,
        ST_IGNORED = 3'd3,
        ST_UNIMPL  = 3'd4
    } status_t;

    // Input item: one decoded instruction
    typedef struct packed {
        logic [OP_W-1:0]        req_type;
        logic [REG_IDX_W-1:0]   reg_a;
        logic [REG_IDX_W-1:0]   reg_b;
        logic [REG_IDX_W-1:0]   reg_c;
        logic signed [IMM_W-1:0] immediate;
        logic signed [IMM_W-1:0] mem_offset;
        logic [REG_IDX_W-1:0]   ptr_reg;
    } req_t;

    // Result item
    typedef struct packed {
        logic                     reg_write;
        logic [REG_IDX_W-1:0]     reg_index;
        logic signed [WORD_W-1:0] reg_value;
        logic                     mem_write;
        logic [MEM_ADDR_W-1:0]    mem_address;
        logic signed [WORD_W-1:0] mem_value;
        logic [STATUS_W-1:0]      status;
    } rsp_t;

    // Write-back control from the execute logic to the state registers
    typedef struct packed {
        logic                 reg_we;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [WORD_W-1:0]    reg_val;
        logic                 halt_set;
    } wb_t;

endpackage

`default_nettype wire

>>> sv/toy_register_machine_execute_top.sv
// Top level of the register machine execute stage: register file, pipeline and handshakes.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------
//  req     | in        | req_valid / req_ready | trmx_pkg::req_t
//  rsp     | out       | rsp_valid / rsp_ready | trmx_pkg::rsp_t
//
// One item per cycle sustained while rsp is not stalled; each item passes through
// the operand-read register, then is executed into the result register.
// Back-to-back register dependencies are forwarded from the execute stage.
// Stores are reported on the result; no store is ever read back, so no data
// memory is kept. Reset clears the register file, halt flag and valid bits.
// A stall on rsp holds the result register and the operand stage behind it.
`default_nettype none

module toy_register_machine_execute_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  trmx_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output trmx_pkg::rsp_t  rsp
);
    import trmx_pkg::*;

    logic [WORD_W-1:0]    rf_reg [NUM_REGS];
    logic                 halted_reg;
    logic                 s1_valid_reg;
    req_t                 s1_req_reg;
    logic [WORD_W-1:0]    s1_rd0_reg;
    logic [WORD_W-1:0]    s1_rd1_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    logic                 s1_advance;
    logic                 s1_fire;
    logic                 req_fire;
    logic [REG_IDX_W-1:0] rd0_addr;
    logic [REG_IDX_W-1:0] rd1_addr;
    logic [WORD_W-1:0]    rd0_next;
    logic [WORD_W-1:0]    rd1_next;
    rsp_t                 exec_rsp;
    wb_t                  exec_wb;

    // Flow control
    assign s1_advance = !rsp_valid_reg || rsp_ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign req_ready  = !s1_valid_reg || s1_advance;
    assign req_fire   = req_valid && req_ready;

    // Read port addresses by operation
    always_comb
    begin
        case (req.req_type)
            OP_SUB, OP_MULT: rd0_addr = req.reg_b;
            OP_SW:           rd0_addr = req.ptr_reg;
            default:         rd0_addr = req.reg_a;
        endcase
        case (req.req_type)
            OP_ADD:  rd1_addr = req.reg_b;
            OP_SW:   rd1_addr = req.reg_a;
            default: rd1_addr = req.reg_c;
        endcase
    end

    // Register file read with forwarding from the item now executing
    always_comb
    begin
        rd0_next = rf_reg[rd0_addr];
        rd1_next = rf_reg[rd1_addr];
        if (s1_fire && exec_wb.reg_we && (exec_wb.reg_idx == rd0_addr))
        begin
            rd0_next = exec_wb.reg_val;
        end
        if (s1_fire && exec_wb.reg_we && (exec_wb.reg_idx == rd1_addr))
        begin
            rd1_next = exec_wb.reg_val;
        end
    end

    trmx_exec u_exec (
        .req    (s1_req_reg),
        .rd0    (s1_rd0_reg),
        .rd1    (s1_rd1_reg),
        .halted (halted_reg),
        .rsp    (exec_rsp),
        .wb     (exec_wb)
    );

    // Architectural state: register file and halt flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rf_reg[i] <= '0;
            end
            halted_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            if (exec_wb.reg_we)
            begin
                rf_reg[exec_wb.reg_idx] <= exec_wb.reg_val;
            end
            if (exec_wb.halt_set)
            begin
                halted_reg <= 1'b1;
            end
        end
    end

    // Operand stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    // Operand stage payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_req_reg <= req;
            s1_rd0_reg <= rd0_next;
            s1_rd1_reg <= rd1_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            rsp_reg <= exec_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> sv/trmx_exec.sv
// Execute logic: ALU, store address check and result formatting for one item.
`default_nettype none

module trmx_exec (
    input  trmx_pkg::req_t                  req,
    input  logic [trmx_pkg::WORD_W-1:0]     rd0,
    input  logic [trmx_pkg::WORD_W-1:0]     rd1,
    input  logic                            halted,
    output trmx_pkg::rsp_t                  rsp,
    output trmx_pkg::wb_t                   wb
);
    import trmx_pkg::*;

    logic [WORD_W-1:0]        imm_ext;
    logic [WORD_W-1:0]        sum_ab;
    logic [WORD_W-1:0]        sum_ai;
    logic [WORD_W-1:0]        diff_bc;
    logic [WORD_W-1:0]        prod_bc;
    logic signed [WORD_W+1:0] st_addr;
    logic                     st_in_range;

    // Arithmetic on the two read ports (port0/port1 assignment set by the op)
    assign imm_ext = {{(WORD_W-IMM_W){req.immediate[IMM_W-1]}}, req.immediate};
    assign sum_ab  = rd0 + rd1;
    assign sum_ai  = rd0 + imm_ext;
    assign diff_bc = rd0 - rd1;
    assign prod_bc = rd0 * rd1;

    // Store address: exact sum of signed base and signed offset
    assign st_addr = $signed({{2{rd0[WORD_W-1]}}, rd0})
                   + $signed({{(WORD_W+2-IMM_W){req.mem_offset[IMM_W-1]}}, req.mem_offset});
    assign st_in_range = !st_addr[WORD_W+1]
                      && (st_addr[WORD_W:0] < (WORD_W+1)'(MEM_WORDS));

    // Result and write-back
    always_comb
    begin
        rsp = '0;
        wb  = '0;
        if (halted)
        begin
            rsp.status = ST_IGNORED;
        end
        else
        begin
            case (req.req_type)
                OP_ADD:
                begin
                    rsp.reg_write = 1'b1;
                    rsp.reg_index = req.reg_c;
                    rsp.reg_value = sum_ab;
                end
                OP_ADDI:
                begin
                    rsp.reg_write = 1'b1;
                    rsp.reg_index = req.reg_b;
                    rsp.reg_value = sum_ai;
                end
                OP_SUB:
                begin
                    rsp.reg_write = 1'b1;
                    rsp.reg_index = req.reg_a;
                    rsp.reg_value = diff_bc;
                end
                OP_MULT:
                begin
                    rsp.reg_write = 1'b1;
                    rsp.reg_index = req.reg_a;
                    rsp.reg_value = prod_bc;
                end
                OP_SW:
                begin
                    if (st_in_range)
                    begin
                        rsp.mem_write   = 1'b1;
                        rsp.mem_address = st_addr[MEM_ADDR_W-1:0];
                        rsp.mem_value   = rd1;
                    end
                    else
                    begin
                        rsp.status = ST_BOUNDS;
                    end
                end
                OP_HALT:
                begin
                    rsp.status  = ST_HALTED;
                    wb.halt_set = 1'b1;
                end
                OP_NOP:
                begin
                    rsp.status = ST_OK;
                end
                default:
                begin
                    rsp.status = ST_UNIMPL;
                end
            endcase
        end
        wb.reg_we  = rsp.reg_write;
        wb.reg_idx = rsp.reg_index;
        wb.reg_val = rsp.reg_value;
    end

endmodule

`default_nettype wire

>>> sv/trmx_checker.sv
// Port-level checks for the execute stage top level, bound to it.
`default_nettype none

module trmx_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input trmx_pkg::req_t  req,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input trmx_pkg::rsp_t  rsp
);
    import trmx_pkg::*;

    logic seen_halt_reg;

    // Track a delivered halt from the result side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
        end
        else if (rsp_valid && rsp_ready && (rsp.status == ST_HALTED))
        begin
            seen_halt_reg <= 1'b1;
        end
    end

    // No result can appear in the cycle after reset
    assert property (@(posedge clk) !rst_n |=> !rsp_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // Once a halt was delivered, every later item is ignored
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && seen_halt_reg |-> rsp.status == ST_IGNORED)
        else $error("item executed after halt");

    // A register write is a plain successful item with no store
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.reg_write |-> rsp.status == ST_OK && !rsp.mem_write)
        else $error("register write with store or error status");

    // Unused store fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.mem_write |-> rsp.mem_address == '0 && rsp.mem_value == '0)
        else $error("store fields set without a store");

endmodule

bind toy_register_machine_execute_top trmx_checker u_trmx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

>>> bench/tb_toy_register_machine_execute_top.sv
// Self-checking bench for the register machine execute stage with an in-bench predictor.
`timescale 1ns / 1ps

module tb_toy_register_machine_execute_top;
    import trmx_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int ITEMS_PER_RUN = 300;
    localparam int DRAIN_CYCLES  = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 100;

    // Codes past NOP are all invalid
    localparam logic [OP_W-1:0] OP_BAD_FIRST = OP_NOP + 1'b1;
    localparam logic [OP_W-1:0] OP_BAD_LAST  = {OP_W{1'b1}};

    // Predicts the execute stage and checks its results in order
    class exec_predictor;
        logic [WORD_W-1:0] regs[NUM_REGS];
        bit                halted;
        rsp_t              pending_results[$];
        int                mismatches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            halted     = 1'b0;
            mismatches = 0;
        endfunction

        // Execute one accepted instruction and queue what it should report
        function void predict_instr(req_t instr);
            rsp_t   res;
            longint addr;
            res = '0;
            if (halted) begin
                res.status = ST_IGNORED;
            end
            else begin
                case (instr.req_type)
                    OP_ADD:
                    begin
                        res.reg_write = 1'b1;
                        res.reg_index = instr.reg_c;
                        res.reg_value = regs[instr.reg_a] + regs[instr.reg_b];
                    end
                    OP_ADDI:
                    begin
                        res.reg_write = 1'b1;
                        res.reg_index = instr.reg_b;
                        res.reg_value = regs[instr.reg_a]
                            + {{(WORD_W-IMM_W){instr.immediate[IMM_W-1]}}, instr.immediate};
                    end
                    OP_SUB:
                    begin
                        res.reg_write = 1'b1;
                        res.reg_index = instr.reg_a;
                        res.reg_value = regs[instr.reg_b] - regs[instr.reg_c];
                    end
                    OP_MULT:
                    begin
                        res.reg_write = 1'b1;
                        res.reg_index = instr.reg_a;
                        res.reg_value = regs[instr.reg_b] * regs[instr.reg_c];
                    end
                    OP_SW:
                    begin
                        // exact sum, no wrap
                        addr = longint'($signed(regs[instr.ptr_reg]))
                            + longint'($signed(instr.mem_offset));
                        if (addr >= 0 && addr < longint'(MEM_WORDS)) begin
                            res.mem_write   = 1'b1;
                            res.mem_address = addr[MEM_ADDR_W-1:0];
                            res.mem_value   = regs[instr.reg_a];
                        end
                        else begin
                            res.status = ST_BOUNDS;
                        end
                    end
                    OP_HALT:
                    begin
                        halted     = 1'b1;
                        res.status = ST_HALTED;
                    end
                    OP_NOP:
                    begin
                    end
                    default:
                    begin
                        res.status = ST_UNIMPL;
                    end
                endcase
                if (res.reg_write)
                    regs[res.reg_index] = res.reg_value;
            end
            pending_results.push_back(res);
        endfunction

        task report(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("%0t ns: mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        // Compare one result against the oldest prediction
        task check_result(rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0) begin
                report("result with no instruction pending");
                return;
            end
            want = pending_results.pop_front();
            compare_field("reg_write", WORD_W'(got.reg_write), WORD_W'(want.reg_write));
            compare_field("reg_index", WORD_W'(got.reg_index), WORD_W'(want.reg_index));
            compare_field("reg_value", got.reg_value, want.reg_value);
            compare_field("mem_write", WORD_W'(got.mem_write), WORD_W'(want.mem_write));
            compare_field("mem_address", WORD_W'(got.mem_address),
                          WORD_W'(want.mem_address));
            compare_field("mem_value", got.mem_value, want.mem_value);
            compare_field("status", WORD_W'(got.status), WORD_W'(want.status));
        endtask
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;

    exec_predictor predictor = new();

    toy_register_machine_execute_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic req_t make_instr(logic [OP_W-1:0] op, int a, int b, int c,
                                        int imm, int off, int ptr);
        req_t instr;
        instr.req_type   = op;
        instr.reg_a      = a[REG_IDX_W-1:0];
        instr.reg_b      = b[REG_IDX_W-1:0];
        instr.reg_c      = c[REG_IDX_W-1:0];
        instr.immediate  = imm[IMM_W-1:0];
        instr.mem_offset = off[IMM_W-1:0];
        instr.ptr_reg    = ptr[REG_IDX_W-1:0];
        return instr;
    endfunction

    // Offer one item after a random gap and wait for it to be taken
    task automatic send_instr(req_t instr);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= instr;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predictor.predict_instr(instr);
    endtask

    // Mostly arithmetic and stores aimed near the memory, plus some noise
    task automatic send_random_instr();
        req_t   instr;
        int     pick;
        int     target;
        int     zero_src;
        longint needed;
        instr = make_instr(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        pick  = $urandom_range(99);
        if (pick < 18)
            instr.req_type = OP_ADD;
        else if (pick < 36)
            instr.req_type = OP_ADDI;
        else if (pick < 50)
            instr.req_type = OP_SUB;
        else if (pick < 62)
            instr.req_type = OP_MULT;
        else if (pick < 84)
            instr.req_type = OP_SW;
        else if (pick < 88)
            instr.req_type = OP_NOP;
        else if (pick < 93)
            instr.req_type = OP_W'($urandom_range(OP_LW, OP_LES));
        else
            instr.req_type = OP_W'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));

        // aim most stores at the memory edges or inside it
        if (instr.req_type == OP_SW && $urandom_range(99) < 80) begin
            if ($urandom_range(99) < 85)
                target = $urandom_range(MEM_WORDS - 1, 0);
            else
                target = $urandom_range(1) ? MEM_WORDS + $urandom_range(1)
                                            : -1 - $urandom_range(1);
            needed = longint'(target) - longint'($signed(predictor.regs[instr.ptr_reg]));
            if (needed < -32768 || needed > 32767) begin
                // base too far off: clear the pointer register first
                zero_src = $urandom_range(NUM_REGS - 1);
                send_instr(make_instr(OP_SUB, int'(instr.ptr_reg), zero_src, zero_src,
                                      $urandom, $urandom, $urandom));
                needed = target;
            end
            instr.mem_offset = needed[IMM_W-1:0];
        end
        send_instr(instr);
    endtask

    // Result side: check on handshake, stall at random
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            predictor.check_result(rsp);
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Watchdog on cycles without any handshake
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Main sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        rsp_stall_pct = 58;

        // directed: immediate extremes, wrapping arithmetic, register 31
        send_instr(make_instr(OP_ADDI, 0, 1, 0, 32767, 0, 0));
        send_instr(make_instr(OP_ADDI, 0, 2, 0, -32768, 0, 0));
        send_instr(make_instr(OP_ADD, 1, 2, 3, 0, 0, 0));
        send_instr(make_instr(OP_MULT, 4, 3, 3, 0, 0, 0));
        send_instr(make_instr(OP_MULT, 5, 1, 1, 0, 0, 0));
        send_instr(make_instr(OP_ADD, 5, 5, 6, 0, 0, 0));
        send_instr(make_instr(OP_ADD, 6, 6, 7, 0, 0, 0));
        send_instr(make_instr(OP_SUB, 8, 2, 6, 0, 0, 0));
        send_instr(make_instr(OP_MULT, 9, 7, 7, 0, 0, 0));
        send_instr(make_instr(OP_ADDI, 31, 31, 31, -1, -1, 31));
        send_instr(make_instr(OP_ADD, 31, 31, 31, 0, 0, 0));
        // stores: both memory ends, just outside, offset extremes, wide bases
        send_instr(make_instr(OP_SW, 6, 0, 0, 0, 0, 0));
        send_instr(make_instr(OP_SW, 31, 0, 0, 0, MEM_WORDS - 1, 0));
        send_instr(make_instr(OP_SW, 7, 0, 0, 0, MEM_WORDS, 0));
        send_instr(make_instr(OP_SW, 7, 0, 0, 0, -1, 0));
        send_instr(make_instr(OP_SW, 7, 0, 0, 0, -32768, 1));
        send_instr(make_instr(OP_SW, 7, 0, 0, 0, -32767, 1));
        send_instr(make_instr(OP_SW, 8, 0, 0, 0, 32767, 6));
        send_instr(make_instr(OP_SW, 9, 0, 0, 0, 2, 31));
        // unfinished and invalid codes, NOP
        send_instr(make_instr(OP_LES, 1, 2, 3, 5, 5, 1));
        send_instr(make_instr(OP_EQL, 1, 2, 3, 5, 5, 1));
        send_instr(make_instr(OP_LW, 1, 2, 3, 5, 5, 1));
        send_instr(make_instr(OP_NOP, 31, 31, 31, -1, -1, 31));
        send_instr(make_instr(OP_BAD_FIRST, 1, 2, 3, 0, 0, 0));
        send_instr(make_instr(OP_BAD_LAST, 31, 31, 31, -1, -1, 31));

        // random, three idle profiles
        repeat (ITEMS_PER_RUN) send_random_instr();
        send_idle_pct = 58;
        rsp_stall_pct = 32;
        repeat (ITEMS_PER_RUN) send_random_instr();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        repeat (ITEMS_PER_RUN) send_random_instr();

        // halt last: everything after it is ignored
        send_instr(make_instr(OP_HALT, 0, 0, 0, 0, 0, 0));
        send_instr(make_instr(OP_ADD, 1, 2, 3, 0, 0, 0));
        send_instr(make_instr(OP_HALT, 0, 0, 0, 0, 0, 0));
        send_instr(make_instr(OP_SW, 6, 0, 0, 0, 0, 0));
        send_instr(make_instr(OP_NOP, 0, 0, 0, 0, 0, 0));
        req_valid <= 1'b0;

        // drain, then watch for stray results
        while (predictor.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (predictor.mismatches == 0 && predictor.pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
